/* rtl/pild_pkg.sv */
// ----------------------------------------------------------------------------
// pild_pkg
// Shared constants and types for the peripheral interrupt level dispatcher.
// ----------------------------------------------------------------------------
package pild_pkg;

  localparam int unsigned NUM_PERIPH_LINES_DEF = 32;
  localparam int unsigned MAX_PERIPH_LINES     = 32;
  localparam int unsigned ASSIGN_WORDS         = 4;
  localparam int unsigned LINES_PER_WORD       = 8;

  localparam int unsigned LEVEL_W  = 4;
  localparam int unsigned IRQ_W    = 6;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned REG_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned S_TDATA_W = 40;   // 4 + 32 bits, padded to bytes
  localparam int unsigned M_TDATA_W = 40;   // 6 + 32 bits, padded to bytes

  localparam logic [LEVEL_W-1:0] TIMER_LEVEL        = 4'd6;
  localparam logic [LEVEL_W-1:0] FIRST_PERIPH_LEVEL = 4'd7;
  localparam logic [LEVEL_W-1:0] LAST_PERIPH_LEVEL  = 4'd13;
  localparam logic [LEVEL_W-1:0] NIBBLE_MASK        = 4'hf;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ASSIGN0  = 3'd0,
    CFG_ASSIGN1  = 3'd1,
    CFG_ASSIGN2  = 3'd2,
    CFG_ASSIGN3  = 3'd3,
    CFG_LINE_MSK = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_TIMER  = 2'd1,
    KIND_PERIPH = 2'd2
  } req_kind_t;

endpackage

/* rtl/peripheral_irq_level_dispatch.sv */
// ----------------------------------------------------------------------------
// peripheral_irq_level_dispatch
// Three-stage dispatcher: per-line level match, priority encode, then the
// interrupt number and spurious event count in the output register.
// ----------------------------------------------------------------------------
// stages: stage 1 does the nibble compares, stage 2 the priority encode,
//   stage 3 the number and counter update
// throughput: one beat per cycle while the output is not stalled by m_axis_tready
// reset: rst clears all stage valid bits, the configuration registers and the
//   spurious counter
module peripheral_irq_level_dispatch #(
  parameter int unsigned NUM_PERIPH_LINES = pild_pkg::NUM_PERIPH_LINES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pild_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pild_pkg::REG_W-1:0]     cfg_data,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // event_level [3:0], pending_lines [35:4], zero pad [39:36]
  input  logic [pild_pkg::S_TDATA_W-1:0] s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // irq_number [5:0], spurious_count [37:6], zero pad [39:38]
  output logic [pild_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // dispatched [0]
  output logic                           m_axis_tuser
);
  import pild_pkg::*;

  localparam int unsigned LINE_W = (NUM_PERIPH_LINES > 1) ? $clog2(NUM_PERIPH_LINES) : 1;

  // configuration
  logic [REG_W-1:0] assign_word [ASSIGN_WORDS];
  logic [REG_W-1:0] line_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < ASSIGN_WORDS; w++) begin
        assign_word[w] <= '0;
      end
      line_mask <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ASSIGN0:  assign_word[0] <= cfg_data;
        CFG_ASSIGN1:  assign_word[1] <= cfg_data;
        CFG_ASSIGN2:  assign_word[2] <= cfg_data;
        CFG_ASSIGN3:  assign_word[3] <= cfg_data;
        CFG_LINE_MSK: line_mask      <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic s1_valid, s2_valid, out_valid;
  logic s1_ready, s2_ready, out_ready;

  assign out_ready     = !out_valid || m_axis_tready;
  assign s2_ready      = !s2_valid || out_ready;
  assign s1_ready      = !s1_valid || s2_ready;
  assign s_axis_tready = s1_ready;

  // stage 1: classify the request and compare every line's level nibble
  logic [LEVEL_W-1:0]          in_level;
  logic [MAX_PERIPH_LINES-1:0] in_pending;
  logic [LEVEL_W-1:0]          in_code;
  req_kind_t                   in_kind;
  logic [NUM_PERIPH_LINES-1:0] in_match;

  assign in_level   = s_axis_tdata[LEVEL_W-1:0];
  assign in_pending = s_axis_tdata[LEVEL_W +: MAX_PERIPH_LINES];
  assign in_code    = (in_level - FIRST_PERIPH_LEVEL) & NIBBLE_MASK;

  always_comb begin
    if (in_level == TIMER_LEVEL) begin
      in_kind = KIND_TIMER;
    end else if (in_level >= FIRST_PERIPH_LEVEL && in_level <= LAST_PERIPH_LEVEL) begin
      in_kind = KIND_PERIPH;
    end else begin
      in_kind = KIND_NONE;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_PERIPH_LINES; i++) begin
      in_match[i] = in_pending[i] && line_mask[i] &&
                    (assign_word[i / LINES_PER_WORD][(i % LINES_PER_WORD) * LEVEL_W +: LEVEL_W]
                     == in_code);
    end
  end

  req_kind_t                   s1_kind;
  logic [NUM_PERIPH_LINES-1:0] s1_match;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= s_axis_tvalid;
    end
    if (s1_ready) begin
      s1_kind  <= in_kind;
      s1_match <= in_match;
    end
  end

  // stage 2: lowest matching line
  logic [LINE_W-1:0] enc_line;
  logic              enc_found;

  always_comb begin
    enc_line = '0;
    for (int i = NUM_PERIPH_LINES - 1; i >= 0; i--) begin
      if (s1_match[i]) begin
        enc_line = LINE_W'(i);
      end
    end
    enc_found = |s1_match;
  end

  req_kind_t         s2_kind;
  logic              s2_found;
  logic [LINE_W-1:0] s2_line;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
    if (s2_ready) begin
      s2_kind  <= s1_kind;
      s2_found <= enc_found;
      s2_line  <= enc_line;
    end
  end

  // stage 3: interrupt number and spurious count
  logic             disp_next;
  logic [IRQ_W-1:0] irq_next;
  logic             spur_hit;

  always_comb begin
    disp_next = 1'b0;
    irq_next  = '0;
    spur_hit  = 1'b0;
    case (s2_kind)
      KIND_TIMER: begin
        disp_next = 1'b1;
        irq_next  = IRQ_W'(TIMER_LEVEL);
      end
      KIND_PERIPH: begin
        if (s2_found) begin
          disp_next = 1'b1;
          irq_next  = IRQ_W'(FIRST_PERIPH_LEVEL) + IRQ_W'(s2_line);
        end else begin
          spur_hit = 1'b1;
        end
      end
      default: ;
    endcase
  end

  logic               out_disp;
  logic [IRQ_W-1:0]   out_irq;
  logic [COUNT_W-1:0] spurious_counter;

  // the counter only moves when a beat enters the output register, so it
  // always matches the beat held there
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      spurious_counter <= '0;
    end else if (out_ready) begin
      out_valid <= s2_valid;
      if (s2_valid && spur_hit) begin
        spurious_counter <= spurious_counter + COUNT_W'(1);
      end
    end
    if (out_ready) begin
      out_disp <= disp_next;
      out_irq  <= irq_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_disp;
  assign m_axis_tdata  = {{(M_TDATA_W - IRQ_W - COUNT_W){1'b0}}, spurious_counter, out_irq};

`ifndef SYNTHESIS
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (spurious_counter != $past(spurious_counter)) |->
      (spurious_counter == $past(spurious_counter) + COUNT_W'(1)))
    else $error("spurious counter moved by more than one");

  a_count_on_load: assert property (@(posedge clk) disable iff (rst)
    !(out_ready && s2_valid) |=> $stable(spurious_counter))
    else $error("spurious counter moved without a beat entering the output");

  a_nodisp_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_disp) |-> (out_irq == '0))
    else $error("undispatched beat carries an interrupt number");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (s1_valid && s2_valid && out_valid && !m_axis_tready))
    else $error("input stalled while pipeline has room");
`endif

endmodule
